### hw/rtl/sdec_pkg.sv
// ----------------------------------------------------------------------------
// sdec_pkg
// Shared constants and types for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sdec_pkg;

  localparam int MagW      = 32;               // input value / magnitude width
  localparam int DigW      = 4;                // one BCD digit
  localparam int CharW     = 8;                // ASCII code width
  localparam int MaxDigits = 10;               // digits of 2^31
  localparam int CntW      = $clog2(MaxDigits);

  localparam logic [CharW-1:0] CharZero  = 8'd48;  // '0'
  localparam logic [CharW-1:0] CharMinus = 8'd45;  // '-'
  localparam logic [DigW-1:0]  DigitMax  = 4'd9;

  // floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit unsigned x
  localparam logic [MagW-1:0] Recip10    = 32'hCCCC_CCCD;
  localparam int              RecipShift = 35;

  // Result of one divide-by-ten step
  typedef struct packed {
    logic [MagW-1:0] quot;
    logic [DigW-1:0] digit;
  } div_res_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SIGN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

endpackage

### hw/rtl/sdec_div10.sv
// ----------------------------------------------------------------------------
// sdec_div10
// Shared divide-by-ten unit: quotient by reciprocal multiply, remainder digit
// from the low bits.
// ----------------------------------------------------------------------------
module sdec_div10 (
  input  logic [sdec_pkg::MagW-1:0] mag,
  output sdec_pkg::div_res_t        res
);
  import sdec_pkg::*;

  logic [2*MagW-1:0] prod;
  logic [MagW-1:0]   quot;
  logic [DigW-1:0]   ten_lo;

  // 32x32 reciprocal multiply, quotient is the top bits
  assign prod = {{MagW{1'b0}}, mag} * {{MagW{1'b0}}, Recip10};
  assign quot = MagW'(prod >> RecipShift);

  // low nibble of 10*q = 8q + 2q; remainder always fits 0..9
  assign ten_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};

  assign res.quot  = quot;
  assign res.digit = mag[DigW-1:0] - ten_lo;

endmodule

### hw/rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a 32-bit two's-complement integer to its decimal ASCII text,
// most significant character first, one character per strobe.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload               direction
//  -------   --------------   -------------------   ---------
//  input     start / busy     value[31:0] signed    in
//  result    strobe           char_code, last_char  out
//
// Sequence: the shared divide-by-ten multiplier yields one digit per cycle,
// least significant first, into a digit buffer; then the characters, a
// minus sign first for a negative value, leave one per cycle, most
// significant first.
// Reset: rst, synchronous, returns the sequencer to idle.
// Stalls: none; the receiver takes each beat in the cycle it is shown.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [sdec_pkg::MagW-1:0] value,
  output logic                          strobe,
  output logic [sdec_pkg::CharW-1:0]    char_code,
  output logic                          last_char
);
  import sdec_pkg::*;

  state_t           state, state_next;
  logic [CntW-1:0]  cnt, cnt_next;
  logic [MagW-1:0]  mag, mag_next;
  logic             neg, neg_next;
  logic [DigW-1:0]  digits [MaxDigits];
  div_res_t         div_res;
  logic             div_done;

  // shared divide unit
  sdec_div10 u_div10 (
    .mag (mag),
    .res (div_res)
  );

  assign div_done = (div_res.quot == '0) || (cnt == CntW'(MaxDigits - 1));

  // sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    mag_next   = mag;
    neg_next   = neg;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          neg_next   = value[MagW-1];
          mag_next   = value[MagW-1] ? (MagW'(0) - MagW'(value)) : MagW'(value);
          cnt_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        mag_next = div_res.quot;
        if (div_done) begin
          state_next = neg ? S_SIGN : S_EMIT;
        end else begin
          cnt_next = cnt + CntW'(1);
        end
      end
      S_SIGN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (cnt == '0) begin
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt - CntW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag <= mag_next;
    neg <= neg_next;
  end

  // digit buffer, least significant digit at index 0
  always_ff @(posedge clk) begin
    if (state == S_DIV) begin
      digits[cnt] <= div_res.digit;
    end
  end

  // result beat
  assign busy      = (state != S_IDLE);
  assign strobe    = (state == S_SIGN) || (state == S_EMIT);
  assign char_code = (state == S_SIGN) ? CharMinus
                                       : (CharZero + CharW'(digits[cnt]));
  assign last_char = (state == S_EMIT) && (cnt == '0);

  // checks
  a_strobe_busy : assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("strobe outside a conversion");

  a_last_idle : assert property (@(posedge clk) disable iff (rst)
    (strobe && last_char) |=> !busy) else $error("busy after last character");

  a_start_quiet : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !strobe)) else $error("beat right after start");

  a_minus_not_last : assert property (@(posedge clk) disable iff (rst)
    (strobe && (char_code == CharMinus)) |-> !last_char)
    else $error("minus sign flagged last");

  a_char_range : assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((char_code == CharMinus) ||
                ((char_code >= CharZero) &&
                 (char_code <= (CharZero + CharW'(DigitMax))))))
    else $error("character out of range");

endmodule

### test/signed_int_to_decimal_ascii_tb.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Self-checking bench for the integer-to-decimal text converter. A short
// table of directed values, covering zero, the extremes and digit-count
// boundaries, is followed by random integers biased toward short numbers
// and powers of ten. Every character beat is checked in order against the
// table's text where it is given, else against a behavioral predictor.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdec_pkg::*;

  localparam int NumRandom  = 390;
  localparam int NumDirect  = 20;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 40;
  localparam int IdlePct    = 25;

  // One character beat as seen on the result ports
  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } char_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic signed [MagW-1:0] value = '0;
  logic                   busy;
  logic                   strobe;
  logic [CharW-1:0]       char_code;
  logic                   last_char;

  char_beat_t pending_chars[$];
  int         n_errors   = 0;
  int         n_chars    = 0;
  int         n_numbers  = 0;
  int         n_negative = 0;
  int         cycles     = 0;
  bit         idle_on    = 1'b1;

  // Directed values; text is filled in only where it is obvious
  logic [MagW-1:0] dir_val [NumDirect] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, -32'sd1000000000,
    32'd999999999, -32'sd10, -32'sd9, 32'd100, 32'd99,
    32'h5555_5555, 32'hAAAA_AAAA, 32'd12345, -32'sd54321, 32'h0F0F_0F0F
  };
  string dir_txt [NumDirect] = '{
    "0", "1", "-1", "9", "10",
    "2147483647", "-2147483648", "-2147483647", "1000000000", "-1000000000",
    "999999999", "-10", "-9", "100", "99",
    "", "", "", "", ""
  };

  signed_int_to_decimal_ascii u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .char_code (char_code),
    .last_char (last_char)
  );

  always #5 clk = ~clk;

  // Queue the characters of a literal string, last flag on the final one
  function automatic void queue_text(input string txt);
    char_beat_t beat;
    for (int i = 0; i < txt.len(); i++) begin
      beat.code = txt[i];
      beat.last = (i == txt.len() - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  // Predict the decimal text of one 32-bit two's-complement integer
  function automatic void queue_decimal(input logic [MagW-1:0] raw);
    logic [MagW-1:0]  mag;
    logic [DigW-1:0]  digs [MaxDigits];
    int               nd;
    char_beat_t       beat;
    mag = raw[MagW-1] ? (~raw + 1'b1) : raw;
    nd  = 0;
    do begin
      digs[nd] = DigW'(mag % 10);
      mag      = mag / 10;
      nd++;
    end while (mag != 0 && nd < MaxDigits);
    if (raw[MagW-1]) begin
      beat.code = CharMinus;
      beat.last = 1'b0;
      pending_chars.push_back(beat);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      beat.code = CharZero + CharW'(digs[i]);
      beat.last = (i == 0);
      pending_chars.push_back(beat);
    end
  endfunction

  // Present one integer, with random idle cycles ahead of it while idle_on is set, and
  // queue its text once the beat is taken
  task automatic send_number(input logic [MagW-1:0] v, input string txt);
    while (idle_on && $urandom_range(0, 99) < IdlePct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    if (txt.len() != 0) queue_text(txt);
    else queue_decimal(v);
    n_numbers++;
    if (v[MagW-1]) n_negative++;
  endtask

  // Random integer: full range, short magnitudes, or near a power of ten
  function automatic logic [MagW-1:0] pick_value();
    logic [MagW-1:0] v;
    logic [MagW-1:0] p;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(0, 31);
      2: v = ~($urandom >> $urandom_range(0, 31)) + 1'b1;
      default: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = p + $urandom_range(0, 4) - 2;
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end
    endcase
    return v;
  endfunction

  // Compare every strobed character with the oldest prediction
  always @(posedge clk) begin
    char_beat_t want;
    if (!rst && strobe) begin
      n_chars++;
      if (pending_chars.size() == 0) begin
        $error("unexpected character beat: char_code %0d last_char %0b",
               char_code, last_char);
        n_errors++;
      end else begin
        want = pending_chars.pop_front();
        if (char_code !== want.code) begin
          $error("char_code: expected %0d, got %0d", want.code, char_code);
          n_errors++;
        end
        if (last_char !== want.last) begin
          $error("last_char: expected %0b, got %0b", want.last, last_char);
          n_errors++;
        end
      end
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NumDirect; i++) send_number(dir_val[i], dir_txt[i]);

    for (int i = 0; i < NumRandom; i++) begin
      // long back-to-back stretch in the middle of the random part
      idle_on = !(i >= 150 && i < 250);
      send_number(pick_value(), "");
    end
    start <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("Converted %0d integers (%0d negative), checked %0d characters.",
             n_numbers, n_negative, n_chars);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
